/* design/swtmr_pkg.sv */
package swtmr_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_NUM_W = 7;
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int PERIOD_W   = 32;
    localparam int HANDLE_W   = 32;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic [1:0] KIND_CREATED  = 2'd0;
    localparam logic [1:0] KIND_REMOVED  = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_REJECTED = 2'd3;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [SLOT_NUM_W-1:0] slot_num_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CREATE = 4'b0010,
        S_CHECK  = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

endpackage

/* design/software_timer_slot_table_top.sv */
// Create walks the slots one per cycle until it finds a free slot or passes the last one.
// Remove and unknown opcodes go straight to the flush state; check walks every slot and
// stalls while a due slot waits on a full output register.
// A new request is taken only once the previous one is done; one subtract-compare unit serves all slots.
// A new request is taken while the previous result still waits in the output register.
// Asynchronous active-low reset frees every slot and empties the output register.
module software_timer_slot_table_top
    import swtmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [31:0]           now_ms,
    input  logic [PERIOD_W-1:0]   period_ms,
    input  logic                  one_shot,
    input  logic [HANDLE_W-1:0]   callback_handle,
    input  logic [SLOT_NUM_W-1:0] slot_to_remove,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [SLOT_NUM_W-1:0] slot_number,
    output logic [HANDLE_W-1:0]   fired_handle,
    output logic                  last_result
);

    state_t                state_reg, state_next;
    slot_idx_t             idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]      fire_cnt_reg, fire_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;

    time_t                 now_reg, now_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic                  one_shot_reg, one_shot_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [1:0]            pend_kind_reg, pend_kind_next;
    slot_num_t             pend_slot_reg, pend_slot_next;
    logic [HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;
    logic [1:0]            result_kind_reg;
    slot_num_t             slot_number_reg;
    logic [HANDLE_W-1:0]   fired_handle_reg;
    logic                  last_result_reg;

    logic [PERIOD_W-1:0]   period_mem [NUM_SLOTS];
    time_t                 last_run_mem [NUM_SLOTS];
    logic                  one_shot_mem [NUM_SLOTS];
    logic [HANDLE_W-1:0]   handle_mem [NUM_SLOTS];

    logic [PERIOD_W-1:0]   rd_period_reg;
    time_t                 rd_last_run_reg;
    logic                  rd_one_shot_reg;
    logic [HANDLE_W-1:0]   rd_handle_reg;

    logic                  in_acc;
    logic                  out_free;
    logic                  out_ld;
    logic                  out_last;
    logic                  create_we;
    logic                  restart_we;
    logic                  slot_due;
    logic                  stall;
    logic                  idx_last;
    time_t                 elapsed;
    slot_num_t             cur_slot_num;
    slot_idx_t             rm_idx;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign idx_last     = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign cur_slot_num = SLOT_NUM_W'(idx_reg) + SLOT_NUM_W'(1);
    assign rm_idx       = SLOT_W'(slot_to_remove - SLOT_NUM_W'(1));
    assign elapsed      = now_reg - rd_last_run_reg;
    assign slot_due     = valid_reg[idx_reg]
                          && (PERIOD_W'(elapsed) >= rd_period_reg)
                          && (fire_cnt_reg < CNT_W'(MAX_RESULTS));
    assign stall        = slot_due && pend_valid_reg && !out_free;

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign slot_number  = slot_number_reg;
    assign fired_handle = fired_handle_reg;
    assign last_result  = last_result_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        fire_cnt_next    = fire_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        now_next         = now_reg;
        period_next      = period_reg;
        one_shot_next    = one_shot_reg;
        handle_next      = handle_reg;
        pend_kind_next   = pend_kind_reg;
        pend_slot_next   = pend_slot_reg;
        pend_handle_next = pend_handle_reg;
        out_ld           = 1'b0;
        out_last         = 1'b0;
        create_we        = 1'b0;
        restart_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    now_next      = now_ms[TIME_WIDTH-1:0];
                    period_next   = period_ms;
                    one_shot_next = one_shot;
                    handle_next   = callback_handle;
                    idx_next      = '0;
                    fire_cnt_next = '0;
                    case (opcode)
                        OP_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        OP_REMOVE:
                        begin
                            if ((slot_to_remove == '0)
                                || (slot_to_remove > SLOT_NUM_W'(NUM_SLOTS)))
                            begin
                                pend_kind_next = KIND_REJECTED;
                                pend_slot_next = '0;
                            end
                            else
                            begin
                                valid_next[rm_idx] = 1'b0;
                                pend_kind_next     = KIND_REMOVED;
                                pend_slot_next     = slot_to_remove;
                            end
                            pend_handle_next = '0;
                            pend_valid_next  = 1'b1;
                            state_next       = S_FLUSH;
                        end
                        OP_CHECK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_CHECK;
                        end
                        default:
                        begin
                            pend_kind_next   = KIND_REJECTED;
                            pend_slot_next   = '0;
                            pend_handle_next = '0;
                            pend_valid_next  = 1'b1;
                            state_next       = S_FLUSH;
                        end
                    endcase
                end
            end
            S_CREATE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    create_we           = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    pend_kind_next      = KIND_CREATED;
                    pend_slot_next      = cur_slot_num;
                    pend_handle_next    = '0;
                    pend_valid_next     = 1'b1;
                    state_next          = S_FLUSH;
                end
                else if (idx_last)
                begin
                    pend_kind_next   = KIND_REJECTED;
                    pend_slot_next   = '0;
                    pend_handle_next = '0;
                    pend_valid_next  = 1'b1;
                    state_next       = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_CHECK:
            begin
                if (!stall)
                begin
                    if (slot_due)
                    begin
                        // The previous fire is known not to be the final one.
                        out_ld           = pend_valid_reg;
                        pend_kind_next   = KIND_FIRED;
                        pend_slot_next   = cur_slot_num;
                        pend_handle_next = rd_handle_reg;
                        pend_valid_next  = 1'b1;
                        fire_cnt_next    = fire_cnt_reg + CNT_W'(1);
                        if (rd_one_shot_reg)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            restart_we = 1'b1;
                        end
                    end
                    if (idx_last)
                    begin
                        state_next = (pend_valid_reg || slot_due) ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_ld          = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        period_reg      <= period_next;
        one_shot_reg    <= one_shot_next;
        handle_reg      <= handle_next;
        pend_kind_reg   <= pend_kind_next;
        pend_slot_reg   <= pend_slot_next;
        pend_handle_reg <= pend_handle_next;
        if (out_ld)
        begin
            result_kind_reg  <= pend_kind_reg;
            slot_number_reg  <= pend_slot_reg;
            fired_handle_reg <= pend_handle_reg;
            last_result_reg  <= out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (create_we)
        begin
            period_mem[idx_reg]   <= period_reg;
            one_shot_mem[idx_reg] <= one_shot_reg;
            handle_mem[idx_reg]   <= handle_reg;
        end
        if (create_we || restart_we)
        begin
            last_run_mem[idx_reg] <= now_reg;
        end
        rd_period_reg   <= period_mem[idx_next];
        rd_last_run_reg <= last_run_mem[idx_next];
        rd_one_shot_reg <= one_shot_mem[idx_next];
        rd_handle_reg   <= handle_mem[idx_next];
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("Pending result left over while idle.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE))
        else $error("Accepted transaction did not start work.");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FLUSH) && out_free) |=> (out_valid_reg && last_result_reg))
        else $error("Final result not marked as last.");

    a_check_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CHECK) && out_ld)
        |=> ((result_kind_reg == KIND_FIRED) && !last_result_reg))
        else $error("Intermediate check result is malformed.");

    a_fire_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (fire_cnt_reg <= CNT_W'(MAX_RESULTS)))
        else $error("Fire count exceeds its limit.");
`endif

endmodule
